### src/stm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stm_pkg
// Shared constants, codes and types of the sparse-table range-minimum block.
// ----------------------------------------------------------------------------
package stm_pkg;

  // Table geometry (MAX_LEN is a power of two, so a table address is
  // simply {level, index}).
  localparam int MAX_LEN   = 1024;
  localparam int LEVELS    = 11;
  localparam int IDX_W     = $clog2(MAX_LEN);       // index within a level
  localparam int LVI_W     = $clog2(LEVELS);        // level field of an address
  localparam int LVL_W     = $clog2(LEVELS + 1);    // level counter, holds LEVELS
  localparam int LEN_W     = $clog2(MAX_LEN + 1);   // length, holds MAX_LEN
  localparam int BLK_W     = LEN_W + 1;             // block size, holds 2*MAX_LEN
  localparam int ADDR_W    = LVI_W + IDX_W;
  localparam int MEM_DEPTH = LEVELS * MAX_LEN;

  // Payload widths
  localparam int CMD_W    = 2;
  localparam int CFG_W    = 11;
  localparam int DEPTH_W  = 10;
  localparam int NODE_W   = 16;
  localparam int STATUS_W = 2;
  localparam int DATA_W   = DEPTH_W + NODE_W;  // depth:node, one compare orders a pair

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_RANGE = 2'd1,
    ST_NOT_BUILT = 2'd2
  } status_e;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DATA_W-1:0] entry_t;

  // One cycle's worth of table port requests
  typedef struct packed {
    logic   we;
    addr_t  waddr;
    entry_t wdata;
    addr_t  raddr_a;
    addr_t  raddr_b;
  } mem_req_t;

  // Smaller of two packed pairs
  function automatic entry_t pair_min(input entry_t a, input entry_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

### src/stm_table_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stm_table_ram
// Sparse table storage: one write port, two read ports, registered reads.
// ----------------------------------------------------------------------------
module stm_table_ram (
  input  logic              clk_i,
  input  stm_pkg::mem_req_t req_i,
  output stm_pkg::entry_t   rdata_a_o,
  output stm_pkg::entry_t   rdata_b_o
);
  import stm_pkg::*;

  entry_t mem [0:MEM_DEPTH-1];
  entry_t rdata_a_q;
  entry_t rdata_b_q;

  // Write and read ports
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_a_q <= mem[req_i.raddr_a];
    rdata_b_q <= mem[req_i.raddr_b];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### src/stm_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stm_builder
// Build sequencer: fills level j from pairwise minima of level j-1, one
// entry per cycle, with an idle gap state between levels to drain the write.
// ----------------------------------------------------------------------------
module stm_builder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [stm_pkg::LEN_W-1:0] len_i,
  input  stm_pkg::entry_t           rdata_a_i,
  input  stm_pkg::entry_t           rdata_b_i,
  output stm_pkg::mem_req_t         req_o,
  output logic                      busy_o,
  output logic                      done_o
);
  import stm_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_GAP,
    B_DONE
  } bstate_e;

  bstate_e           state_q, state_d;
  logic [LVL_W-1:0]  lvl_q, lvl_d;
  logic [BLK_W-1:0]  blk_q, blk_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [LEN_W-1:0]  n_q, n_d;
  logic              wr_pend_q, wr_pend_d;
  addr_t             wr_addr_q, wr_addr_d;

  logic [LVI_W-1:0]  src_lvl;
  logic [IDX_W-1:0]  half;
  logic              last;
  logic              more;

  // Source level and partner offset of the level being written
  assign src_lvl = LVI_W'(lvl_q - LVL_W'(1));
  assign half    = IDX_W'(blk_q >> 1);
  assign last    = (BLK_W'(idx_q) + blk_q) == BLK_W'(n_q);
  assign more    = (lvl_q < LVL_W'(LEVELS)) && (blk_q <= BLK_W'(n_q));

  // Sequencer
  always_comb begin
    state_d   = state_q;
    lvl_d     = lvl_q;
    blk_d     = blk_q;
    idx_d     = idx_q;
    n_d       = n_q;
    wr_pend_d = 1'b0;
    wr_addr_d = wr_addr_q;
    case (state_q)
      B_IDLE: begin
        if (start_i) begin
          n_d   = len_i;
          lvl_d = LVL_W'(1);
          blk_d = BLK_W'(2);
          idx_d = '0;
          state_d = (BLK_W'(len_i) >= BLK_W'(2)) ? B_RUN : B_DONE;
        end
      end
      B_RUN: begin
        wr_pend_d = 1'b1;
        wr_addr_d = {lvl_q[LVI_W-1:0], idx_q};
        if (last) begin
          lvl_d   = lvl_q + LVL_W'(1);
          blk_d   = blk_q << 1;
          state_d = B_GAP;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      B_GAP: begin
        // last write of the previous level lands this cycle
        idx_d   = '0;
        state_d = more ? B_RUN : B_DONE;
      end
      B_DONE: begin
        state_d = B_IDLE;
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      wr_pend_q <= 1'b0;
      lvl_q     <= '0;
      blk_q     <= '0;
      idx_q     <= '0;
      n_q       <= '0;
      wr_addr_q <= '0;
    end else begin
      state_q   <= state_d;
      wr_pend_q <= wr_pend_d;
      lvl_q     <= lvl_d;
      blk_q     <= blk_d;
      idx_q     <= idx_d;
      n_q       <= n_d;
      wr_addr_q <= wr_addr_d;
    end
  end

  // Table requests: reads issue in RUN, the minimum is written in the cycle after
  always_comb begin
    req_o.we      = wr_pend_q;
    req_o.waddr   = wr_addr_q;
    req_o.wdata   = pair_min(rdata_a_i, rdata_b_i);
    req_o.raddr_a = {src_lvl, idx_q};
    req_o.raddr_b = {src_lvl, idx_q + half};
  end

  assign busy_o = (state_q != B_IDLE);
  assign done_o = (state_q == B_DONE);

endmodule

### src/stm_query.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stm_query
// Query address generation and range check, plus the two-stage result
// pipeline shared by every transaction's response.
// ----------------------------------------------------------------------------
module stm_query (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         issue_i,
  input  logic                         is_query_i,
  input  logic [stm_pkg::IDX_W-1:0]    left_i,
  input  logic [stm_pkg::IDX_W-1:0]    right_i,
  input  logic                         built_i,
  input  logic [stm_pkg::LEN_W-1:0]    built_len_i,
  input  stm_pkg::entry_t              rdata_a_i,
  input  stm_pkg::entry_t              rdata_b_i,
  output stm_pkg::addr_t               raddr_a_o,
  output stm_pkg::addr_t               raddr_b_o,
  output logic                         valid_o,
  output logic [stm_pkg::NODE_W-1:0]   node_o,
  output logic [stm_pkg::DEPTH_W-1:0]  depth_o,
  output logic [stm_pkg::STATUS_W-1:0] status_o
);
  import stm_pkg::*;

  logic [LEN_W-1:0]   span;
  logic [LVI_W-1:0]   lg;
  logic [LEN_W-1:0]   pw;
  logic [IDX_W-1:0]   right_blk;
  status_e            status_c;

  logic               s1_valid_q;
  logic               s1_use_q;
  status_e            s1_status_q;

  logic               out_valid_q;
  logic [NODE_W-1:0]  node_q;
  logic [DEPTH_W-1:0] depth_q;
  status_e            status_q;
  entry_t             m;

  // Block size: floor(log2(span)), clamped to the top level
  assign span = LEN_W'(right_i) - LEN_W'(left_i) + LEN_W'(1);

  always_comb begin
    lg = '0;
    for (int k = 0; k < LEN_W; k++) begin
      if (span[k]) begin
        lg = LVI_W'(k);
      end
    end
    if (lg > LVI_W'(LEVELS - 1)) begin
      lg = LVI_W'(LEVELS - 1);
    end
  end

  assign pw        = LEN_W'(1) << lg;
  assign right_blk = IDX_W'(LEN_W'(right_i) + LEN_W'(1) - pw);
  assign raddr_a_o = {lg, left_i};
  assign raddr_b_o = {lg, right_blk};

  // Range check, table state first
  always_comb begin
    if (!built_i) begin
      status_c = ST_NOT_BUILT;
    end else if ((left_i > right_i) || (LEN_W'(right_i) >= built_len_i)) begin
      status_c = ST_BAD_RANGE;
    end else begin
      status_c = ST_OK;
    end
  end

  assign m = pair_min(rdata_a_i, rdata_b_i);

  // Stage 1 waits for the table read; stage 2 drives the result ports
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= issue_i;
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_use_q    <= is_query_i && (status_c == ST_OK);
    s1_status_q <= is_query_i ? status_c : ST_OK;
    status_q    <= s1_status_q;
    if (s1_use_q) begin
      node_q  <= m[NODE_W-1:0];
      depth_q <= m[DATA_W-1:NODE_W];
    end else begin
      node_q  <= '0;
      depth_q <= '0;
    end
  end

  assign valid_o  = out_valid_q;
  assign node_o   = node_q;
  assign depth_o  = depth_q;
  assign status_o = status_q;

endmodule

### src/sparse_table_range_min_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_table_range_min_top
// Sparse-table range-minimum engine over (depth, node) pairs.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken when start is high and busy is low. cmd_i selects
//   load (write one pair at position_i), build (fill levels 1.. from level 0
//   over the first array_length positions) or query (minimum over
//   [range_left_i, range_right_i]). Every transaction returns one result,
//   shown for one cycle with result_valid_o high; the receiver cannot stall.
//   Load, query and unused commands answer through the response pipeline
//   (stage 1, then the result registers); while no build runs, one may be
//   issued every cycle (the two table reads of a query share the registered
//   dual-read table RAM). A build holds busy high while it walks the table
//   one entry per cycle, apart from a gap state between levels; its result
//   follows in the cycle after busy drops. array_length is written through
//   cfg_we_i / cfg_wdata_i; the user writes it only while idle (the block
//   does not enforce it). Reset clears the built flag, sets array_length to
//   1; table contents are undefined until loaded; no clearing pass is run.
// ----------------------------------------------------------------------------
module sparse_table_range_min_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [stm_pkg::CMD_W-1:0]      cmd_i,
  input  logic [stm_pkg::IDX_W-1:0]      position_i,
  input  logic [stm_pkg::DEPTH_W-1:0]    elem_depth_i,
  input  logic [stm_pkg::NODE_W-1:0]     elem_node_i,
  input  logic [stm_pkg::IDX_W-1:0]      range_left_i,
  input  logic [stm_pkg::IDX_W-1:0]      range_right_i,
  input  logic                           cfg_we_i,
  input  logic [stm_pkg::CFG_W-1:0]      cfg_wdata_i,
  output logic                           result_valid_o,
  output logic [stm_pkg::NODE_W-1:0]     result_node_o,
  output logic [stm_pkg::DEPTH_W-1:0]    result_depth_o,
  output logic [stm_pkg::STATUS_W-1:0]   status_o
);
  import stm_pkg::*;

  logic [CFG_W-1:0] array_length_q;
  logic             built_q, built_d;
  logic [LEN_W-1:0] built_len_q, built_len_d;
  logic [LEN_W-1:0] len_sat;

  cmd_e     cmd;
  logic     accept;
  logic     do_load;
  logic     do_build;
  logic     do_query;

  mem_req_t bld_req;
  mem_req_t ram_req;
  logic     bld_busy;
  logic     bld_done;
  entry_t   rdata_a;
  entry_t   rdata_b;
  addr_t    q_raddr_a;
  addr_t    q_raddr_b;

  function automatic logic cfg_wdata_sat(input logic [CFG_W-1:0] v);
    return (v > CFG_W'(MAX_LEN));
  endfunction

  // Command decode
  assign cmd      = cmd_e'(cmd_i);
  assign accept   = start && !busy;
  assign do_load  = accept && (cmd == CMD_LOAD);
  assign do_build = accept && (cmd == CMD_BUILD);
  assign do_query = accept && (cmd == CMD_QUERY);
  assign busy     = bld_busy;

  // Build length saturates at the table width
  assign len_sat = (cfg_wdata_sat(array_length_q)) ? LEN_W'(MAX_LEN)
                                                   : LEN_W'(array_length_q);

  // Configuration register and table status
  always_comb begin
    built_d     = built_q;
    built_len_d = built_len_q;
    if (do_load) begin
      built_d = 1'b0;
    end else if (do_build) begin
      built_d     = 1'b1;
      built_len_d = len_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      array_length_q <= CFG_W'(1);
      built_q        <= 1'b0;
      built_len_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        array_length_q <= cfg_wdata_i;
      end
      built_q     <= built_d;
      built_len_q <= built_len_d;
    end
  end

  // Table port: builder owns it while running, else loads and queries
  always_comb begin
    if (bld_busy) begin
      ram_req = bld_req;
    end else begin
      ram_req.we      = do_load;
      ram_req.waddr   = {LVI_W'(0), position_i};
      ram_req.wdata   = {elem_depth_i, elem_node_i};
      ram_req.raddr_a = q_raddr_a;
      ram_req.raddr_b = q_raddr_b;
    end
  end

  stm_table_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  stm_builder u_builder (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (do_build),
    .len_i     (len_sat),
    .rdata_a_i (rdata_a),
    .rdata_b_i (rdata_b),
    .req_o     (bld_req),
    .busy_o    (bld_busy),
    .done_o    (bld_done)
  );

  // Response pipeline: every non-build transaction, and the build at its end
  stm_query u_query (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     ((accept && !do_build) || bld_done),
    .is_query_i  (do_query),
    .left_i      (range_left_i),
    .right_i     (range_right_i),
    .built_i     (built_q),
    .built_len_i (built_len_q),
    .rdata_a_i   (rdata_a),
    .rdata_b_i   (rdata_b),
    .raddr_a_o   (q_raddr_a),
    .raddr_b_o   (q_raddr_b),
    .valid_o     (result_valid_o),
    .node_o      (result_node_o),
    .depth_o     (result_depth_o),
    .status_o    (status_o)
  );

endmodule
